>>> hw/rtl/redl_pkg.sv
package redl_pkg;

   typedef struct packed {
      logic a_level;
      logic b_level;
      logic switch_level;
      logic read_rotation;
      logic read_press;
   } req_word_type;

   typedef struct packed {
      logic signed [1:0] direction;
      logic              pressed;
      logic              locked_out;
   } rsp_word_type;

   localparam logic [1:0] DIR_NONE  = 2'b00;
   localparam logic [1:0] DIR_PLUS  = 2'b01;
   localparam logic [1:0] DIR_MINUS = 2'b11;

   localparam logic [1:0] LINES_BOTH_LOW = 2'b00;
   localparam logic [1:0] LINES_B_HIGH   = 2'b01;
   localparam logic [1:0] LINES_A_HIGH   = 2'b10;

   localparam int unsigned DEBOUNCE_W = 16;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd120;

endpackage

>>> hw/rtl/redl_tick.sv
module redl_tick (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fire,
   input  redl_pkg::req_word_type                 word,
   input  logic                                   csr_write,
   input  logic [redl_pkg::DEBOUNCE_W-1:0]        csr_data,
   output redl_pkg::rsp_word_type                 result
);
   import redl_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic                  prev_a_ff, prev_b_ff, prev_sw_ff;
   logic                  a_mark_ff, b_mark_ff;
   logic [1:0]            dir_ff;
   logic                  press_ff;
   logic [DEBOUNCE_W-1:0] count_ff;

   logic                  a_mark_in, b_mark_in;
   logic [1:0]            dir_in;
   logic                  press_in;
   logic [DEBOUNCE_W-1:0] count_in;

   logic                  a_fall, b_fall, sw_fall, lock;
   logic [1:0]            lines, dir_new;
   logic                  press_new;

   always_comb begin
      lines     = {word.a_level, word.b_level};
      a_fall    = prev_a_ff & ~word.a_level;
      b_fall    = prev_b_ff & ~word.b_level;
      sw_fall   = prev_sw_ff & ~word.switch_level;
      a_mark_in = a_mark_ff;
      b_mark_in = b_mark_ff;
      dir_new   = dir_ff;
      press_new = press_ff;
      count_in  = count_ff;
      lock      = count_ff != '0;
      if (lock) begin
         count_in = count_ff - 1'b1;
      end else begin
         if (a_fall) begin
            if (!b_mark_in && lines == LINES_BOTH_LOW) begin
               a_mark_in = 1'b1;
            end else if (lines == LINES_B_HIGH) begin
               b_mark_in = 1'b0;
               dir_new   = DIR_MINUS;
               count_in  = debounce_ff;
               lock      = debounce_ff != '0;
            end
         end
         if (!lock && b_fall) begin
            if (!a_mark_in && lines == LINES_BOTH_LOW) begin
               b_mark_in = 1'b1;
            end else if (lines == LINES_A_HIGH) begin
               a_mark_in = 1'b0;
               dir_new   = DIR_PLUS;
               count_in  = debounce_ff;
               lock      = debounce_ff != '0;
            end
         end
         if (!lock && sw_fall) begin
            press_new = 1'b1;
         end
      end
      result.direction  = dir_new;
      result.pressed    = press_new;
      result.locked_out = count_in != '0;
      dir_in   = word.read_rotation ? DIR_NONE : dir_new;
      press_in = word.read_press ? 1'b0 : press_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_write) begin
         debounce_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff  <= 1'b1;
         prev_b_ff  <= 1'b1;
         prev_sw_ff <= 1'b1;
         a_mark_ff  <= 1'b0;
         b_mark_ff  <= 1'b0;
         dir_ff     <= DIR_NONE;
         press_ff   <= 1'b0;
         count_ff   <= '0;
      end else if (fire) begin
         prev_a_ff  <= word.a_level;
         prev_b_ff  <= word.b_level;
         prev_sw_ff <= word.switch_level;
         a_mark_ff  <= a_mark_in;
         b_mark_ff  <= b_mark_in;
         dir_ff     <= dir_in;
         press_ff   <= press_in;
         count_ff   <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      fire && count_ff != '0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("lockout count did not step down");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff) && $stable(dir_ff) && $stable(press_ff))
      else $error("state changed without a word");

   a_press_locked: assert property (@(posedge clock) disable iff (reset)
      fire && count_ff != '0 && !word.read_press |=> press_ff == $past(press_ff))
      else $error("press latched during lockout");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      dir_ff == DIR_NONE || dir_ff == DIR_PLUS || dir_ff == DIR_MINUS)
      else $error("bad direction code");
`endif

endmodule

>>> hw/rtl/rotary_encoder_direction_latch.sv
// Rotary encoder direction latch.
// req channel: one sample word per tick with lines A, B, the push switch and
// the two read strobes. rsp channel: one word per sample with the latched
// direction (-1, 0, +1), the press flag and the lockout status.
// csr channel: write of the 16-bit debounce tick count; always ready. The
// user is to write it only while no sample is in flight; the block itself
// does not enforce this. Reset value is 120. Pipeline: an accepted sample
// sits in the input register, is evaluated against the encoder state as it
// leaves and goes into the result register; two register stages in all.
// Throughput: one sample per cycle while rsp is not held; the single
// evaluation stage updates state and result register together.
// Reset: lines taken as high, marks, latches and lockout cleared, both
// stages empty.
// Stall: while rsp is held, the result stays and the input register
// still fills; req_ready drops only once both stages are full.
module rotary_encoder_direction_latch (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  redl_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output redl_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [redl_pkg::DEBOUNCE_W-1:0] csr_data
);
   import redl_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type result;
   logic         advance, take;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign take         = req_valid && req_ready;
   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;
   assign csr_ready    = 1'b1;

   redl_tick u_tick (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .word      (s1_word_ff),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

endmodule

>>> tb/direction_latch_checker.sv
module direction_latch_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  redl_pkg::req_word_type          req_word,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  redl_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [redl_pkg::DEBOUNCE_W-1:0] csr_data,
   output int                              mismatches,
   output int                              outstanding,
   output int                              compared
);
   timeunit 1ns;
   timeprecision 1ps;
   import redl_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce;
   logic [DEBOUNCE_W-1:0] lock_left;
   logic                  last_a, last_b, last_sw;
   logic                  mark_a, mark_b;
   logic [1:0]            held_dir;
   logic                  held_press;
   rsp_word_type          due_words[$];

   // One sample tick of the encoder logic; returns the word it reports.
   function automatic rsp_word_type predict_tick(input req_word_type w);
      logic [1:0]   lines;
      logic         fall_a, fall_b, fall_sw, locked;
      rsp_word_type r;
      lines   = {w.a_level, w.b_level};
      fall_a  = last_a & ~w.a_level;
      fall_b  = last_b & ~w.b_level;
      fall_sw = last_sw & ~w.switch_level;
      locked  = (lock_left != '0);
      if (locked) begin
         lock_left = lock_left - 1'b1;
      end else begin
         if (fall_a) begin
            if (!mark_b && lines == LINES_BOTH_LOW) begin
               mark_a = 1'b1;
            end else if (lines == LINES_B_HIGH) begin
               mark_b    = 1'b0;
               held_dir  = DIR_MINUS;
               lock_left = debounce;
               locked    = (lock_left != '0);
            end
         end
         if (!locked && fall_b) begin
            if (!mark_a && lines == LINES_BOTH_LOW) begin
               mark_b = 1'b1;
            end else if (lines == LINES_A_HIGH) begin
               mark_a    = 1'b0;
               held_dir  = DIR_PLUS;
               lock_left = debounce;
               locked    = (lock_left != '0);
            end
         end
         if (!locked && fall_sw)
            held_press = 1'b1;
      end
      last_a  = w.a_level;
      last_b  = w.b_level;
      last_sw = w.switch_level;
      r.direction  = held_dir;
      r.pressed    = held_press;
      r.locked_out = (lock_left != '0);
      if (w.read_rotation)
         held_dir = DIR_NONE;
      if (w.read_press)
         held_press = 1'b0;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      if (mismatches < 10)
         $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         debounce    = DEBOUNCE_RESET;
         lock_left   = '0;
         last_a      = 1'b1;
         last_b      = 1'b1;
         last_sw     = 1'b1;
         mark_a      = 1'b0;
         mark_b      = 1'b0;
         held_dir    = DIR_NONE;
         held_press  = 1'b0;
         mismatches  = 0;
         compared    = 0;
         due_words.delete();
      end else begin
         if (csr_valid && csr_ready)
            debounce = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               note_failure($sformatf("unexpected word dir %0d pressed %0b lock %0b",
                  rsp_word.direction, rsp_word.pressed, rsp_word.locked_out));
            end else begin
               want = due_words.pop_front();
               if (rsp_word.direction !== want.direction || rsp_word.pressed !== want.pressed
                  || rsp_word.locked_out !== want.locked_out)
                  note_failure($sformatf(
                     "word %0d: exp dir %0d pressed %0b lock %0b, got dir %0d pressed %0b lock %0b",
                     compared, want.direction, want.pressed, want.locked_out,
                     rsp_word.direction, rsp_word.pressed, rsp_word.locked_out));
               compared++;
            end
         end
         if (req_valid && req_ready)
            due_words.push_back(predict_tick(req_word));
      end
      outstanding <= due_words.size();
   end

endmodule

>>> tb/tb_rotary_encoder_direction_latch.sv
module tb_rotary_encoder_direction_latch;
   timeunit 1ns;
   timeprecision 1ps;
   import redl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [DEBOUNCE_W-1:0] csr_data;

   int          mismatches;
   int          outstanding;
   int          compared;
   int          cycle_count = 0;
   int          samples_sent;
   int          settings_used;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        hold_request;
   int unsigned hold_left;
   logic        line_a, line_b, line_sw;

   rotary_encoder_direction_latch dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   direction_latch_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .compared    (compared)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random backpressure, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_word_type sample_word(input logic a, b, sw, rd_rot, rd_press);
      req_word_type w;
      w.a_level       = a;
      w.b_level       = b;
      w.switch_level  = sw;
      w.read_rotation = rd_rot;
      w.read_press    = rd_press;
      return w;
   endfunction

   task automatic send_sample(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [DEBOUNCE_W-1:0] ticks);
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // single-line gray steps most often, some simultaneous toggles of both lines, switch presses, noise
   task automatic wiggle_encoder(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            if ($urandom_range(1))
               line_a = ~line_a;
            else
               line_b = ~line_b;
         end else if (pick < 48) begin
            line_a = ~line_a;
            line_b = ~line_b;
         end else if (pick < 58) begin
            line_sw = ~line_sw;
         end else if (pick < 64) begin
            {line_a, line_b, line_sw} = 3'($urandom_range(7));
         end
         send_sample(sample_word(line_a, line_b, line_sw,
            $urandom_range(3) == 0, $urandom_range(3) == 0));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      hold_request  = 1'b0;
      samples_sent  = 0;
      settings_used = 0;
      send_idle_pct = 12;
      recv_idle_pct = 83;
      line_a        = 1'b1;
      line_b        = 1'b1;
      line_sw       = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_debounce('0);
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));   // A leads: -1
      send_sample(sample_word(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
      send_sample(sample_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));   // B mark, press
      send_sample(sample_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
      send_sample(sample_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));   // A fall blocked by B mark
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));   // +1, B mark kept
      send_sample(sample_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));   // -1 clears B mark
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
      send_sample(sample_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));   // both fall: A mark
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b1));   // +1 clears A mark, press
      drain_block();
      write_debounce(16'd3);
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_sample(sample_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));   // decision hides same-tick press
      drain_block();
      write_debounce(16'd1);                                   // mid-lockout write
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
      send_sample(sample_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
      send_sample(sample_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
      send_sample(sample_word(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
      send_sample(sample_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      drain_block();

      write_debounce(16'd2);
      wiggle_encoder(450);
      drain_block();

      send_idle_pct = 83;
      recv_idle_pct <= 12;
      write_debounce(16'd1);
      wiggle_encoder(450);
      drain_block();

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      write_debounce('0);
      wiggle_encoder(100);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      wiggle_encoder(100);
      drain_block();
      wiggle_encoder(100);
      drain_block();

      write_debounce(DEBOUNCE_RESET);
      wiggle_encoder(100);
      drain_block();
      write_debounce('1);
      wiggle_encoder(50);
      drain_block();

      $display("Sent %0d samples under %0d debounce settings, 0 through 65535", samples_sent,
         settings_used);
      $display("Compared %0d result words, %0d mismatches", compared, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
